// ----- hdl/rknn_pkg.sv -----
// ----------------------------------------------------------------------------
// rknn_pkg
// Shared widths, operation codes and controller/datapath interface structs
// for the radius k-nearest-neighbor block.
// ----------------------------------------------------------------------------
`default_nettype none

package rknn_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int COORD_W = 16;
    localparam int QIDX_W  = 8;
    localparam int NIDX_W  = 8;
    localparam int DIST_W  = 33;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int S3_W    = COORD_W + 2;

    // Stream word layout
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;
    localparam int S_OP_LSB  = 0;
    localparam int S_X_LSB   = S_OP_LSB + OP_W;
    localparam int S_Y_LSB   = S_X_LSB + COORD_W;
    localparam int S_S_LSB   = S_Y_LSB + COORD_W;
    localparam int S_QI_LSB  = S_S_LSB + COORD_W;
    localparam int S_USED_W  = S_QI_LSB + QIDX_W;
    localparam int M_USED_W  = NIDX_W + DIST_W;

    // Point memory word: {scale, y, x}
    localparam int PT_W = 3 * COORD_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // append point
        logic clear;      // empty table
        logic q_start;    // capture query index, read its point
        logic q_latch;    // query point arrives: latch, init list
        logic scan_step;  // read next table entry
        logic emit;       // pop list head
        logic err_sel;    // present error result
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic q_in_range; // query index below point count
        logic scan_last;  // current scan address is the last entry
        logic pipe_busy;  // compare pipeline holds work
        logic list_last;  // list head is the final entry
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/rknn_ram.sv -----
// ----------------------------------------------------------------------------
// rknn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rknn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/rknn_ctrl.sv -----
// ----------------------------------------------------------------------------
// rknn_ctrl
// Operation sequencer: load/clear on accept, query read, scan, drain, emit, error result.
// ----------------------------------------------------------------------------
`default_nettype none

module rknn_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [rknn_pkg::OP_W-1:0] op,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output rknn_pkg::dp_cmd_t            cmd,
    input  rknn_pkg::dp_stat_t           stat
);

    import rknn_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_QREAD = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_ERR   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (op)
                        OP_LOAD:  cmd.load  = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_QUERY: begin
                            if (stat.q_in_range) begin
                                cmd.q_start = 1'b1;
                                state_next  = ST_QREAD;
                            end else begin
                                state_next  = ST_ERR;
                            end
                        end
                        default: ;  // unused code: dropped
                    endcase
                end
            end
            ST_QREAD: begin
                cmd.q_latch = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.emit = 1'b1;
                    if (stat.list_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                m_tvalid    = 1'b1;
                cmd.err_sel = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rknn_dp.sv -----
// ----------------------------------------------------------------------------
// rknn_dp
// Point table, point count, distance/scale compare pipeline and the sorted
// neighbor list.
// ----------------------------------------------------------------------------
`default_nettype none

module rknn_dp #(
    parameter int MAX_POINTS    = 256,
    parameter int MAX_NEIGHBORS = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  rknn_pkg::dp_cmd_t                  cmd,
    output rknn_pkg::dp_stat_t                 stat,
    input  wire logic [rknn_pkg::COORD_W-1:0]  in_x,
    input  wire logic [rknn_pkg::COORD_W-1:0]  in_y,
    input  wire logic [rknn_pkg::COORD_W-1:0]  in_scale,
    input  wire logic [rknn_pkg::QIDX_W-1:0]   in_qi,
    output logic      [rknn_pkg::NIDX_W-1:0]   out_index,
    output logic      [rknn_pkg::DIST_W-1:0]   out_dist,
    output logic                               out_status,
    output logic                               out_last
);

    import rknn_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int QW    = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
    localparam int IW    = (IDX_W > NIDX_W) ? IDX_W : NIDX_W;
    localparam int NB    = MAX_NEIGHBORS;

    // ---------------- point table and count ----------------
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [PT_W-1:0]  rd_data;
    logic             wr_en;
    logic [QW-1:0]    qi_ext;

    assign full    = (count_reg == CNT_W'(MAX_POINTS));
    assign wr_en   = cmd.load && !full;
    assign wr_addr = count_reg[IDX_W-1:0];
    assign qi_ext  = QW'(in_qi);

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (wr_en) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // ---------------- query point ----------------
    logic [IDX_W-1:0]   qi_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [COORD_W-1:0] qx_reg, qy_reg, qs_reg;
    logic [S3_W-1:0]    qs3_reg;
    logic [PROD_W-1:0]  limit_reg;
    logic [COORD_W-1:0] rd_x, rd_y, rd_s;

    assign rd_x    = rd_data[COORD_W-1:0];
    assign rd_y    = rd_data[2*COORD_W-1:COORD_W];
    assign rd_s    = rd_data[3*COORD_W-1:2*COORD_W];
    assign rd_addr = cmd.q_start ? qi_ext[IDX_W-1:0] : j_reg;

    rknn_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_pts (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({in_scale, in_y, in_x}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // ---------------- compare pipeline ----------------
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]   j1_reg, j2_reg, j3_reg, j4_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic [PROD_W-1:0]  dx2_reg, dy2_reg;
    logic [DIST_W-1:0]  d4_reg;
    logic [COORD_W-1:0] dx, dy;
    logic [S3_W-1:0]    s3;
    logic               scale_ok;
    logic [DIST_W-1:0]  dsum;

    assign dx       = (rd_x > qx_reg) ? rd_x - qx_reg : qx_reg - rd_x;
    assign dy       = (rd_y > qy_reg) ? rd_y - qy_reg : qy_reg - rd_y;
    assign s3       = {1'b0, rd_s, 1'b0} + S3_W'(rd_s);
    assign scale_ok = (S3_W'(rd_s) <= qs3_reg) && (S3_W'(qs_reg) <= s3);
    assign dsum     = DIST_W'(dx2_reg) + DIST_W'(dy2_reg);

    // ---------------- sorted neighbor list ----------------
    logic [IDX_W-1:0]  lidx_reg [NB];
    logic [DIST_W-1:0] ldst_reg [NB];
    logic [NB-1:0]     lval_reg;
    logic [IDX_W-1:0]  lidx_next [NB];
    logic [DIST_W-1:0] ldst_next [NB];
    logic [NB-1:0]     lval_next;
    logic [NB:0]       le_ext;
    logic [NB:0]       lval_ext;
    logic [IW-1:0]     head_idx;

    always_comb begin
        le_ext[0] = 1'b1;
        for (int k = 0; k < NB; k++) begin
            le_ext[k+1] = lval_reg[k] && (ldst_reg[k] <= d4_reg);
        end
        for (int k = 0; k < NB; k++) begin
            lidx_next[k] = lidx_reg[k];
            ldst_next[k] = ldst_reg[k];
            lval_next[k] = lval_reg[k];
        end
        if (cmd.q_latch) begin
            lidx_next[0] = qi_reg;
            ldst_next[0] = '0;
            lval_next    = NB'(1);
        end else if (cmd.emit) begin
            for (int k = 0; k < NB - 1; k++) begin
                lidx_next[k] = lidx_reg[k+1];
                ldst_next[k] = ldst_reg[k+1];
                lval_next[k] = lval_reg[k+1];
            end
            lval_next[NB-1] = 1'b0;
        end else if (v4_reg) begin
            // entries with distance <= d stay; d lands after them; rest shift up
            for (int k = 0; k < NB; k++) begin
                if (!le_ext[k+1]) begin
                    if (le_ext[k]) begin
                        lidx_next[k] = j4_reg;
                        ldst_next[k] = d4_reg;
                        lval_next[k] = 1'b1;
                    end
                end
            end
            for (int k = 1; k < NB; k++) begin
                if (!le_ext[k+1] && !le_ext[k]) begin
                    lidx_next[k] = lidx_reg[k-1];
                    ldst_next[k] = ldst_reg[k-1];
                    lval_next[k] = lval_reg[k-1];
                end
            end
        end
    end

    assign lval_ext = {1'b0, lval_reg};
    assign head_idx = IW'(lidx_reg[0]);

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            lval_reg  <= '0;
        end else begin
            count_reg <= count_next;
            v1_reg    <= cmd.scan_step && (j_reg != qi_reg);
            v2_reg    <= v1_reg && scale_ok;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg && (dsum <= DIST_W'(limit_reg));
            lval_reg  <= lval_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.q_start) begin
            qi_reg <= qi_ext[IDX_W-1:0];
        end
        if (cmd.q_latch) begin
            qx_reg    <= rd_x;
            qy_reg    <= rd_y;
            qs_reg    <= rd_s;
            qs3_reg   <= s3;
            limit_reg <= PROD_W'(rd_s) * PROD_W'(rd_s);
            j_reg     <= '0;
        end else if (cmd.scan_step) begin
            j_reg <= j_reg + IDX_W'(1);
        end
        j1_reg  <= j_reg;
        j2_reg  <= j1_reg;
        dx_reg  <= dx;
        dy_reg  <= dy;
        j3_reg  <= j2_reg;
        dx2_reg <= PROD_W'(dx_reg) * PROD_W'(dx_reg);
        dy2_reg <= PROD_W'(dy_reg) * PROD_W'(dy_reg);
        j4_reg  <= j3_reg;
        d4_reg  <= dsum;
        for (int k = 0; k < NB; k++) begin
            lidx_reg[k] <= lidx_next[k];
            ldst_reg[k] <= ldst_next[k];
        end
    end

    // ---------------- status and result ----------------
    assign stat.q_in_range = (qi_ext < QW'(count_reg));
    assign stat.scan_last  = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign stat.pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg;
    assign stat.list_last  = !lval_ext[1];

    assign out_index  = cmd.err_sel ? '0 : head_idx[NIDX_W-1:0];
    assign out_dist   = cmd.err_sel ? '0 : ldst_reg[0];
    assign out_status = cmd.err_sel;
    assign out_last   = cmd.err_sel || !lval_ext[1];

endmodule

`default_nettype wire

// ----- hdl/radius_knn_scale_filtered_neighbors.sv -----
// ----------------------------------------------------------------------------
// radius_knn_scale_filtered_neighbors
// Point table with fixed-radius, scale-filtered nearest-neighbor queries.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports                       Contents
//  s_       in   s_tvalid/s_tready/s_tdata   operation, center_x/y, scale, query index
//  m_       out  m_tvalid/m_tready/m_tdata   neighbor index, squared distance
//                m_tuser, m_tlast            status, last result of a query
//
//  Load and clear complete on accept. A query passes through the accept,
//  a query-point read, a scan of one table entry per cycle through the
//  single RAM read port and a pipeline drain before its first result;
//  results then follow in list order, each held until m_tready takes it.
//  One operation is in flight at a time; s_tready is high only when idle.
//  A stalled m_tready holds the current result and freezes the block.
//  Reset (aresetn low, synchronous) empties the table; no clearing pass.
//
`default_nettype none

module radius_knn_scale_filtered_neighbors #(
    parameter int MAX_POINTS    = 256,
    parameter int MAX_NEIGHBORS = 6
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [1:0] operation, [17:2] center_x, [33:18] center_y,
    // [49:34] point_scale, [57:50] query_index, [63:58] zero
    input  wire logic [rknn_pkg::S_TDATA_W-1:0]    s_tdata,

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] neighbor_index, [40:8] squared_distance, [47:41] zero
    output logic      [rknn_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] status: 1 when the query index was not loaded
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    import rknn_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [NIDX_W-1:0] res_index;
    logic [DIST_W-1:0] res_dist;

    // Input field unpack
    logic [OP_W-1:0]    in_op;
    logic [COORD_W-1:0] in_x, in_y, in_scale;
    logic [QIDX_W-1:0]  in_qi;

    assign in_op    = s_tdata[S_OP_LSB +: OP_W];
    assign in_x     = s_tdata[S_X_LSB  +: COORD_W];
    assign in_y     = s_tdata[S_Y_LSB  +: COORD_W];
    assign in_scale = s_tdata[S_S_LSB  +: COORD_W];
    assign in_qi    = s_tdata[S_QI_LSB +: QIDX_W];

    // Sequencer
    rknn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (in_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Table, compare pipeline and sorted list
    rknn_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_scale   (in_scale),
        .in_qi      (in_qi),
        .out_index  (res_index),
        .out_dist   (res_dist),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    // Result pack; the list head is a register, so m_tdata is stable under stall
    assign m_tdata = {(M_TDATA_W - M_USED_W)'(0), res_dist, res_index};

endmodule

`default_nettype wire

// ----- tb/radius_knn_scale_filtered_neighbors_tb.sv -----
// ----------------------------------------------------------------------------
// radius_knn_scale_filtered_neighbors_tb
// Self-checking bench for the scale-filtered radius neighbor table. A local
// copy of the point table predicts every query answer; results are matched
// field by field against the oldest pending answer as they leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radius_knn_scale_filtered_neighbors_tb;

    import rknn_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int LIST_DEPTH    = 6;
    localparam int RANDOM_ITEMS  = 130;
    localparam int MAX_GAP       = 13;
    localparam int HOLD_CYCLES   = 300;   // long receiver stall for the backpressure test
    localparam int TAIL_CYCLES   = 40;    // settle time after the last result
    localparam int LIMIT_CYCLES  = 400000;

    // Encoding the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One neighbor result as it leaves the block
    typedef struct packed {
        logic [NIDX_W-1:0] nidx;
        logic [DIST_W-1:0] sq_dist;
        logic              status;
        logic              last;
    } nbr_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // [1:0] operation, [17:2] center_x, [33:18] center_y,
    // [49:34] point_scale, [57:50] query_index, [63:58] zero
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [7:0] neighbor_index, [40:8] squared_distance, [47:41] zero
    logic [M_TDATA_W-1:0] m_tdata;
    // [0] status
    logic                 m_tuser;
    logic                 m_tlast;

    // Shadow copy of the point table
    logic [COORD_W-1:0] tbl_x [TABLE_DEPTH];
    logic [COORD_W-1:0] tbl_y [TABLE_DEPTH];
    logic [COORD_W-1:0] tbl_s [TABLE_DEPTH];
    int                 tbl_count;

    nbr_result_t pending_neighbors[$];
    nbr_result_t head_want;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  no_idle;             // both sides run back to back while set
    int  hold_asks      = 0;  // long receiver stalls asked for by the tests
    int  holds_started  = 0;
    int  hold_left      = 0;
    int  taken_count    = 0;  // result transfers seen by the checker
    int  taken_seen     = 0;
    int  stall_left     = 0;

    radius_knn_scale_filtered_neighbors #(
        .MAX_POINTS   (TABLE_DEPTH),
        .MAX_NEIGHBORS(LIST_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog: a hung block ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_neighbors.size());
            $display("radius_knn_scale_filtered_neighbors verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Appends one predicted result to the scoreboard
    task automatic queue_answer(input nbr_result_t r);
        pending_neighbors = {pending_neighbors, r};
    endtask

    // ------------------------------------------------------------------------
    // Predictor: tracks loads and clears, and builds the sorted answer list
    // of a query exactly as the block should walk it.
    // ------------------------------------------------------------------------
    task automatic apply_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] px,
                              input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] ps,
                              input logic [QIDX_W-1:0] qi);
        logic [NIDX_W-1:0] list_idx [LIST_DEPTH];
        logic [DIST_W-1:0] list_dist [LIST_DEPTH];
        longint unsigned   dx, dy, dsq, radius_sq, sq, sj;
        int                n, pos, kend;
        nbr_result_t       r;
        case (op)
            OP_LOAD: begin
                // full table drops the load without a trace
                if (tbl_count < TABLE_DEPTH) begin
                    tbl_x[tbl_count] = px;
                    tbl_y[tbl_count] = py;
                    tbl_s[tbl_count] = ps;
                    tbl_count++;
                end
            end
            OP_CLEAR: tbl_count = 0;
            OP_QUERY: begin
                if (qi >= tbl_count) begin
                    r = '{nidx: '0, sq_dist: '0, status: 1'b1, last: 1'b1};
                    queue_answer(r);
                end else begin
                    sq        = tbl_s[qi];
                    radius_sq = sq * sq;
                    // query point always heads the list
                    list_idx[0]  = qi;
                    list_dist[0] = '0;
                    n = 1;
                    for (int j = 0; j < tbl_count; j++) begin
                        if (j == qi)
                            continue;
                        dx  = (tbl_x[qi] > tbl_x[j]) ? tbl_x[qi] - tbl_x[j] : tbl_x[j] - tbl_x[qi];
                        dy  = (tbl_y[qi] > tbl_y[j]) ? tbl_y[qi] - tbl_y[j] : tbl_y[j] - tbl_y[qi];
                        dsq = dx * dx + dy * dy;
                        sj  = tbl_s[j];
                        if (dsq > radius_sq || sq > 3 * sj || sj > 3 * sq)
                            continue;
                        // insert after every entry at equal or shorter distance
                        pos = n;
                        while (pos > 0 && list_dist[pos-1] > dsq)
                            pos--;
                        if (pos >= LIST_DEPTH)
                            continue;
                        kend = (n < LIST_DEPTH) ? n : LIST_DEPTH - 1;
                        for (int k = kend; k > pos; k--) begin
                            list_idx[k]  = list_idx[k-1];
                            list_dist[k] = list_dist[k-1];
                        end
                        list_idx[pos]  = j[NIDX_W-1:0];
                        list_dist[pos] = dsq[DIST_W-1:0];
                        if (n < LIST_DEPTH)
                            n++;
                    end
                    for (int k = 0; k < n; k++) begin
                        r = '{nidx: list_idx[k], sq_dist: list_dist[k], status: 1'b0,
                              last: (k == n - 1)};
                        queue_answer(r);
                    end
                end
            end
            default: ;  // unused code, no effect
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender: one transfer on the input channel, with a random lead-in gap.
    // Valid drops after the transfer; a following call raises it again at
    // the same falling edge, so back-to-back items see no gap.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] px,
                             input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] ps,
                             input logic [QIDX_W-1:0] qi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {6'b0, qi, ps, py, px, op};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        apply_item(op, px, py, ps, qi);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Sender pause: nothing goes out until every pending result is back
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_neighbors.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[COORD_W-1:0];
    endfunction

    // Loads n points scattered around one center; scales vary up to 4x either
    // way from the base, so the ratio filter cuts some of them.
    task automatic load_cluster(input int n, input int base_scale);
        int cx, cy, lo, hi;
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
        lo = (base_scale / 4 > 0) ? base_scale / 4 : 1;
        hi = (base_scale * 4 < 65535) ? base_scale * 4 : 65535;
        for (int i = 0; i < n; i++)
            send_item(OP_LOAD,
                      clamp_coord(cx + $urandom_range(0, 2 * base_scale) - base_scale),
                      clamp_coord(cy + $urandom_range(0, 2 * base_scale) - base_scale),
                      COORD_W'($urandom_range(lo, hi)), '0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall before each result, plus one long hold on request
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_asks != holds_started) begin
            holds_started = hold_asks;
            hold_left     = HOLD_CYCLES;
        end
        if (taken_count != taken_seen) begin
            taken_seen = taken_count;
            stall_left = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Checker: every result transfer against the oldest pending answer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            taken_count++;
            if (pending_neighbors.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                head_want = pending_neighbors.pop_front();
                if (m_tdata[7:0] !== head_want.nidx)
                    report_mismatch("neighbor_index", m_tdata[7:0], head_want.nidx);
                if (m_tdata[40:8] !== head_want.sq_dist)
                    report_mismatch("squared_distance", m_tdata[40:8], head_want.sq_dist);
                if (m_tuser !== head_want.status)
                    report_mismatch("status", m_tuser, head_want.status);
                if (m_tlast !== head_want.last)
                    report_mismatch("last", m_tlast, head_want.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner points: full-range coordinates and scales, exact ratio boundary,
    // ties, coincident points, zero scale, unused code, bad indexes.
    task automatic test_directed();
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_QUERY, '0, '0, '0, 8'd0);              // empty table
        send_item(OP_LOAD, 16'd0, 16'd0, 16'hFFFF, '0);     // 0 origin, widest radius
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0); // 1 far corner
        send_item(OP_LOAD, 16'hFFFF, 16'd0, 16'd21845, '0); // 2 on the radius, ratio exactly 3
        send_item(OP_LOAD, 16'd0, 16'hFFFF, 16'd21844, '0); // 3 ratio just over 3
        send_item(OP_LOAD, 16'd0, 16'd0, 16'hFFFF, '0);     // 4 same spot as 0
        send_item(OP_LOAD, 16'd100, 16'd0, 16'd30000, '0);  // 5 tie with 6
        send_item(OP_LOAD, 16'd0, 16'd100, 16'd30000, '0);  // 6
        send_item(OP_LOAD, 16'd50, 16'd50, 16'hFFFF, '0);   // 7
        send_item(OP_LOAD, 16'd10, 16'd10, 16'hFFFF, '0);   // 8 overflows the list
        send_item(OP_LOAD, 16'd0, 16'd0, 16'd0, '0);        // 9 zero scale
        send_item(OP_LOAD, 16'd0, 16'd0, 16'd0, '0);        // 10 zero scale twin
        send_item(OP_QUERY, '0, '0, '0, 8'd0);
        send_item(OP_QUERY, '0, '0, '0, 8'd4);              // self ahead of coincident 0
        send_item(OP_QUERY, '0, '0, '0, 8'd1);
        send_item(OP_QUERY, '0, '0, '0, 8'd2);
        send_item(OP_QUERY, '0, '0, '0, 8'd9);
        send_item(OP_UNUSED, 16'hA5A5, 16'h5A5A, 16'h1234, 8'd3);
        send_item(OP_QUERY, '0, '0, '0, 8'd255);            // out of range
        send_item(OP_QUERY, '0, '0, '0, 8'd11);             // first index past the end
        wait_drained();
    endtask

    // Receiver holds off while queries keep coming: the block must freeze on
    // its current result and keep its input closed.
    task automatic test_backpressure();
        no_idle = 1'b1;
        send_item(OP_CLEAR, '0, '0, '0, '0);
        load_cluster(8, 400);
        @(negedge aclk);
        hold_asks++;
        for (int i = 0; i < 6; i++)
            send_item(OP_QUERY, '0, '0, '0, QIDX_W'($urandom_range(0, 8)));
        no_idle = 1'b0;
        wait_drained();
    endtask

    // Mostly clear/load/query sequences on small clustered tables with random
    // content; the rest is noise over the whole field ranges.
    task automatic test_random_sequences();
        int items_done, n, base, nq;
        logic [OP_W-1:0] op;
        items_done = 0;
        while (items_done < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0) begin
                n    = $urandom_range(2, 16);
                base = ($urandom_range(0, 7) == 0) ? $urandom_range(8000, 65535)
                                                   : $urandom_range(1, 2000);
                send_item(OP_CLEAR, '0, '0, '0, '0);
                load_cluster(n, base);
                nq = $urandom_range(1, 4);
                for (int q = 0; q < nq; q++)
                    send_item(OP_QUERY, '0, '0, '0,
                              QIDX_W'(($urandom_range(0, 9) == 0) ? $urandom_range(n, 255)
                                                                  : $urandom_range(0, n - 1)));
                items_done += 1 + n + nq;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    op = OP_W'($urandom_range(0, 3));
                    send_item(op, COORD_W'($urandom_range(0, 65535)),
                              COORD_W'($urandom_range(0, 65535)),
                              COORD_W'($urandom_range(1, 65535)),
                              QIDX_W'($urandom_range(0, 255)));
                    if (op != OP_UNUSED)
                        items_done++;
                end
            end
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        tbl_count      = 0;
        no_idle        = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_x[i] = '0;
            tbl_y[i] = '0;
            tbl_s[i] = '0;
        end
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_backpressure();
        test_random_sequences();

        // wait_drained already let the tail pass; leftovers would be failures
        if (mismatch_count == 0 && pending_neighbors.size() == 0)
            $display("radius_knn_scale_filtered_neighbors verification clean");
        else
            $display("radius_knn_scale_filtered_neighbors verification failed");
        $finish;
    end

endmodule
